### sv/neighbor_token_decoder_assert.svh
// Assertion macros shared by the checker of the neighbor token decoder.
`ifndef NEIGHBOR_TOKEN_DECODER_ASSERT_SVH
`define NEIGHBOR_TOKEN_DECODER_ASSERT_SVH

// Clocked check with the reset disable.
`define NTD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("%m: check failed");

// Check that a condition holds whenever a result is offered.
`define NTD_ASSERT_ON_OUT(lbl, cond) \
	`NTD_ASSERT(lbl, out_valid |-> (cond))

`endif

### sv/ntd_pkg.sv
// Types and constants of the neighbor token decoder.
`timescale 1ns / 1ps

package ntd_pkg;

	// Step cache geometry.
	localparam int CACHE_AW    = 16;
	localparam int CACHE_DEPTH = 1 << CACHE_AW;

	// Varint byte layout.
	localparam logic [7:0] MORE_BIT     = 8'h80;
	localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
	localparam logic [2:0] MAX_GROUPS   = 3'd5;

	// Token candidate from the varint assembler.
	typedef struct packed {
		logic        fire;
		logic        path;
		logic [30:0] node;
		logic [31:0] steps;
	} token_t;

endpackage

### sv/neighbor_token_decoder.sv
// Top level of the neighbor token decoder.
//
// Input channel: one byte of the compressed neighbor stream per request
// (in_valid, in_stall, byte_in). Output channel: one token per request
// (out_valid, out_stall, path_token, node, step_count, node_range_error).
// Bytes form little-endian 7-bit varints; a byte that finishes a plain token
// or the steps of a path token yields at most one result, every other byte none.
// Pipeline: the edge that accepts a token's last byte reads the step cache and loads
// the compare stage; the compare stage loads the output register once that
// register is free, that is, not holding a stalled result.
// Throughput: one byte per cycle while not stalled; the cache read-modify-write is
// pipelined with forwarding, so back-to-back path tokens on one node need no bubble.
// Reset: the 65536-entry step cache is cleared by a sweep, one entry a cycle;
// in_stall stays high until the sweep ends.
// When out_stall holds a result, one more finished token waits in the compare
// stage; bytes are still taken until that stage is full.
`timescale 1ns / 1ps

module neighbor_token_decoder #(
	parameter int NODE_COUNT = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        path_token,
	output logic [15:0] node,
	output logic [31:0] step_count,
	output logic        node_range_error
);

	ntd_pkg::token_t              cand;
	logic [ntd_pkg::CACHE_AW-1:0] rd_addr;
	logic [15:0]                  rd_data;
	logic                         clearing;
	logic                         accept;
	logic                         cand_err;

	logic        valid_s1;
	logic        path_s1;
	logic [15:0] node_s1;
	logic [31:0] steps_s1;
	logic        err_s1;

	logic        out_valid_q;
	logic        path_q;
	logic [15:0] node_q;
	logic [31:0] steps_q;
	logic        err_q;

	logic out_free;
	logic go_s1;
	logic newer_s1;
	logic emit_s1;
	logic wr_en;

	// Request handshake.
	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && out_free;
	assign in_stall = clearing || (valid_s1 && !out_free);
	assign accept   = in_valid && !in_stall;

	ntd_varint u_varint (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (accept),
		.byte_in (byte_in),
		.cand    (cand),
		.rd_addr (rd_addr)
	);

	assign cand_err = {1'b0, cand.node} >= 32'(NODE_COUNT);

	// Compare stage: an in-range path token passes only if its steps beat the cached value.
	assign newer_s1 = {16'b0, rd_data} < steps_s1;
	assign emit_s1  = !path_s1 || err_s1 || newer_s1;
	assign wr_en    = go_s1 && path_s1 && !err_s1 && newer_s1;

	ntd_cache u_cache (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (node_s1[ntd_pkg::CACHE_AW-1:0]),
		.wr_data  (steps_s1[15:0]),
		.clearing (clearing)
	);

	// Compare stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= cand.fire;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Compare stage payload.
	always_ff @(posedge clk) begin
		if (accept && cand.fire) begin
			path_s1  <= cand.path;
			node_s1  <= cand.node[15:0];
			steps_s1 <= cand.steps;
			err_s1   <= cand_err;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go_s1 && emit_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (go_s1) begin
			path_q  <= path_s1;
			node_q  <= node_s1;
			steps_q <= steps_s1;
			err_q   <= err_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign path_token       = path_q;
	assign node             = node_q;
	assign step_count       = steps_q;
	assign node_range_error = err_q;

endmodule

### sv/ntd_varint.sv
// Varint assembler and token head tracker of the neighbor token decoder.
`timescale 1ns / 1ps

module ntd_varint (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [7:0]                     byte_in,
	output ntd_pkg::token_t                cand,
	output logic [ntd_pkg::CACHE_AW-1:0]   rd_addr
);

	logic [31:0] accum_q;
	logic [2:0]  group_q;
	logic        await_q;
	logic [30:0] held_q;

	logic [6:0]  payload;
	logic [31:0] shifted;
	logic [31:0] val;
	logic        more;
	logic [2:0]  group_next;

	// Place the payload group at its bit position; groups past the fifth are dropped.
	always_comb begin
		payload = 7'(byte_in & ntd_pkg::PAYLOAD_MASK);
		more    = (byte_in & ntd_pkg::MORE_BIT) != 8'h00;
		case (group_q)
			3'd0:    shifted = {25'b0, payload};
			3'd1:    shifted = {18'b0, payload, 7'b0};
			3'd2:    shifted = {11'b0, payload, 14'b0};
			3'd3:    shifted = {4'b0, payload, 21'b0};
			3'd4:    shifted = {payload[3:0], 28'b0};
			default: shifted = 32'b0;
		endcase
		val        = accum_q | shifted;
		group_next = (group_q < ntd_pkg::MAX_GROUPS) ? group_q + 3'd1 : group_q;
	end

	// A finished varint either emits a plain token, arms a path head, or closes a path.
	always_comb begin
		cand.fire  = take && !more && (await_q || !val[0]);
		cand.path  = await_q;
		cand.node  = await_q ? held_q : val[31:1];
		cand.steps = await_q ? val : 32'b0;
	end

	assign rd_addr = held_q[ntd_pkg::CACHE_AW-1:0];

	// Varint and token state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			group_q <= '0;
			await_q <= 1'b0;
			held_q  <= '0;
		end else if (take) begin
			if (more) begin
				accum_q <= val;
				group_q <= group_next;
			end else begin
				accum_q <= '0;
				group_q <= '0;
				if (!await_q) begin
					if (val[0]) begin
						held_q  <= val[31:1];
						await_q <= 1'b1;
					end
				end else begin
					await_q <= 1'b0;
				end
			end
		end
	end

endmodule

### sv/ntd_cache.sv
// Step cache memory with clearing sweep and write-to-read forwarding.
`timescale 1ns / 1ps

module ntd_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [ntd_pkg::CACHE_AW-1:0] rd_addr,
	output logic [15:0]                  rd_data,
	input  logic                         wr_en,
	input  logic [ntd_pkg::CACHE_AW-1:0] wr_addr,
	input  logic [15:0]                  wr_data,
	output logic                         clearing
);

	logic [15:0] mem [ntd_pkg::CACHE_DEPTH];

	logic                         clr_busy_q;
	logic [ntd_pkg::CACHE_AW-1:0] clr_addr_q;
	logic [15:0]                  rd_q;
	logic                         byp_q;
	logic [15:0]                  byp_data_q;

	logic                         mem_we;
	logic [ntd_pkg::CACHE_AW-1:0] mem_wa;
	logic [15:0]                  mem_wd;

	// The clearing sweep owns the write port after reset.
	always_comb begin
		mem_we = clr_busy_q || wr_en;
		mem_wa = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wd = clr_busy_q ? 16'h0000 : wr_data;
	end

	// Clearing sweep, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A write to the address being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_data_q <= wr_data;
		end
	end

	assign rd_data  = byp_q ? byp_data_q : rd_q;
	assign clearing = clr_busy_q;

endmodule

### sv/ntd_checker.sv
// Port-level checker of the neighbor token decoder and its bind.
`timescale 1ns / 1ps
`include "neighbor_token_decoder_assert.svh"

module ntd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        path_token,
	input logic [15:0] node,
	input logic [31:0] step_count,
	input logic        node_range_error
);

	// A held result keeps its contents.
	`NTD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(step_count) && $stable(node))

	// A single neighbor carries no steps.
	`NTD_ASSERT_ON_OUT(a_plain_zero, path_token || step_count == 32'd0)

	// An in-range path token only passes with steps above the cached value, so never zero.
	`NTD_ASSERT_ON_OUT(a_path_nonzero, !path_token || node_range_error || step_count != 32'd0)

endmodule

bind neighbor_token_decoder ntd_checker u_ntd_checker (.*);

### sim/testbench.sv
// Self-checking testbench for the neighbor token decoder: byte stream in, tokens out.
`timescale 1ns / 1ps

module testbench;

	localparam int NODE_LIMIT    = 65536;
	localparam int ITEM_TARGET   = 1700;
	localparam int HOLD_AT       = 600;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_AT      = 1100;
	localparam int QUIET_TAIL    = 250;
	// The reset sweep alone keeps the input stalled while it clears every cache entry.
	localparam int QUIET_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic        path;
		logic [15:0] node;
		logic [31:0] steps;
		logic        err;
	} token_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_in = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        path_token;
	logic [15:0] node;
	logic [31:0] step_count;
	logic        node_range_error;

	// Byte stream waiting to be sent, and tokens the decoder still owes.
	logic [7:0]    stream_bytes[$];
	token_result_t pending_tokens[$];
	token_result_t head_token;

	// Shadow decoder state.
	logic [15:0] step_cache[ntd_pkg::CACHE_DEPTH];
	logic [31:0] word_acc;
	logic [2:0]  group_cnt;
	logic        await_steps;
	logic [30:0] held_node;

	int total_bytes;
	int bytes_sent;
	int tokens_seen;
	int mismatches;
	int plain_cnt;
	int path_cnt;
	int dropped_cnt;
	int range_cnt;
	int overlong_bytes;
	int send_gap;
	int stall_left;
	int hold_left;
	int quiet_cycles;
	bit drain_wait;
	bit drain_done;
	bit hold_done;

	neighbor_token_decoder #(
		.NODE_COUNT(NODE_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.path_token(path_token),
		.node(node),
		.step_count(step_count),
		.node_range_error(node_range_error)
	);

	// Clock and a single reset at the start.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Random idling is allowed in three windows out of four and never near the end.
	function automatic bit idling_window(input int n);
		return (n < total_bytes - QUIET_TAIL) && ((n / 150) % 4 != 3);
	endfunction

	// Queue one byte at the end of the stream.
	task automatic add_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endtask

	// Queue one token the decoder owes.
	task automatic owe_token(input token_result_t t);
		pending_tokens.insert(pending_tokens.size(), t);
	endtask

	// Append one varint, with extra groups beyond the minimal length when asked.
	task automatic push_varint(input logic [31:0] value, input int extra);
		int groups;
		int count;
		logic [6:0] payload;
		logic more;
		groups = 1;
		while (groups < 5 && (value >> (7 * groups)) != 0)
			groups++;
		count = groups + extra;
		for (int i = 0; i < count; i++) begin
			if (i < 4)
				payload = 7'(value >> (7 * i));
			else if (i == 4)
				payload = {3'($urandom_range(0, 7)), value[31:28]};
			else
				payload = 7'($urandom);
			more = (i < count - 1);
			add_byte({more, payload});
		end
	endtask

	// Append a whole token: the head varint and, for a path token, its steps.
	task automatic push_token(input logic path, input logic [30:0] node_idx,
			input logic [31:0] steps, input int extra);
		push_varint({node_idx, path}, extra);
		if (path)
			push_varint(steps, 0);
	endtask

	// Shadow decoder: consume one accepted byte and queue the token it finishes.
	task automatic decode_byte(input logic [7:0] b);
		logic [31:0] word;
		logic [30:0] idx;
		token_result_t t;
		if (group_cnt < ntd_pkg::MAX_GROUPS) begin
			word_acc = word_acc | (32'(b & ntd_pkg::PAYLOAD_MASK) << (7 * group_cnt));
			group_cnt = group_cnt + 3'd1;
		end else begin
			overlong_bytes++;
		end
		if ((b & ntd_pkg::MORE_BIT) == 8'h00) begin
			word = word_acc;
			word_acc = '0;
			group_cnt = '0;
			if (!await_steps) begin
				idx = word[31:1];
				if (!word[0]) begin
					t = '{path: 1'b0, node: idx[15:0], steps: 32'd0,
						err: (idx >= NODE_LIMIT)};
					owe_token(t);
					plain_cnt++;
					if (t.err)
						range_cnt++;
				end else begin
					held_node = idx;
					await_steps = 1'b1;
				end
			end else begin
				await_steps = 1'b0;
				if (held_node >= NODE_LIMIT) begin
					t = '{path: 1'b1, node: held_node[15:0], steps: word, err: 1'b1};
					owe_token(t);
					path_cnt++;
					range_cnt++;
				end else if ({16'h0000, step_cache[held_node[15:0]]} >= word) begin
					dropped_cnt++;
				end else begin
					t = '{path: 1'b1, node: held_node[15:0], steps: word, err: 1'b0};
					owe_token(t);
					step_cache[held_node[15:0]] = word[15:0];
					path_cnt++;
				end
			end
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Stimulus: directed tokens first, then a random mix, then wait for the end.
	initial begin
		int pick;
		int extra;
		logic [30:0] node_idx;
		logic [31:0] steps;
		for (int i = 0; i < ntd_pkg::CACHE_DEPTH; i++)
			step_cache[i] = 16'h0000;
		word_acc = '0;
		group_cnt = '0;
		await_steps = 1'b0;
		held_node = '0;

		// Smallest plain token, then the largest node spelled with trailing groups.
		push_token(1'b0, 31'd0, 32'd0, 0);
		push_token(1'b0, 31'h7FFFFFFF, 32'd0, 2);
		// Zero steps never beat an empty entry; wide steps win but store zero.
		push_token(1'b1, 31'd3, 32'd0, 0);
		push_token(1'b1, 31'd3, 32'h0001_0000, 0);
		push_token(1'b1, 31'd3, 32'd5, 0);
		push_token(1'b1, 31'd3, 32'd5, 0);
		// Out-of-range nodes, on a path token and on a plain token.
		push_token(1'b1, 31'h10000, 32'd0, 0);
		push_token(1'b0, 31'h12345, 32'd0, 0);

		while (stream_bytes.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				add_byte(8'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					node_idx = 31'($urandom_range(0, 15));
				else if (pick < 80)
					node_idx = 31'($urandom_range(0, 65535));
				else if (pick < 90)
					node_idx = 31'($urandom_range(65536, 32'h7FFFFFFF));
				else
					node_idx = ($urandom_range(0, 1) != 0) ? 31'h0000FFFF : 31'h7FFFFFFF;
				pick = $urandom_range(0, 99);
				if (pick < 40)
					steps = $urandom_range(0, 40);
				else if (pick < 65)
					steps = $urandom_range(0, 65535);
				else if (pick < 85)
					steps = $urandom;
				else if (pick < 90)
					steps = 32'h0000FFFF;
				else if (pick < 95)
					steps = 32'h00010000;
				else
					steps = 32'hFFFFFFFF;
				extra = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
				push_token($urandom_range(0, 99) < 55, node_idx, steps, extra);
			end
		end
		total_bytes = stream_bytes.size();

		do
			@(posedge clk);
		while (bytes_sent != total_bytes || pending_tokens.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			$display("%0t: %0d tokens never arrived", $time, pending_tokens.size());
			mismatches++;
		end
		$display("Sent %0d bytes; got %0d tokens: %0d plain, %0d path, %0d out of range.",
			bytes_sent, tokens_seen, plain_cnt, path_cnt, range_cnt);
		$display("Path tokens dropped by the step cache: %0d; ignored overlong bytes: %0d.",
			dropped_cnt, overlong_bytes);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Byte sender: holds a stalled request, idles in bursts, pauses once to drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			byte_in <= 8'h00;
			send_gap = 0;
			drain_wait = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(byte_in);
				bytes_sent++;
			end
			if (in_valid && in_stall) begin
				// The stalled request stays on the port unchanged.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (drain_wait) begin
				in_valid <= 1'b0;
				if (pending_tokens.size() == 0)
					drain_wait = 1'b0;
			end else if (!drain_done && bytes_sent >= DRAIN_AT) begin
				drain_done = 1'b1;
				drain_wait = 1'b1;
				in_valid <= 1'b0;
			end else if (stream_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idling_window(bytes_sent) && $urandom_range(0, 99) < 6) begin
				send_gap = $urandom_range(1, 16) - 1;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				byte_in <= stream_bytes.pop_front();
			end
		end
	end

	// Token receiver: checks each accepted token, stalls in bursts and once at length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				tokens_seen++;
				if (pending_tokens.size() == 0) begin
					$display("%0t: unexpected token path=%b node=%h steps=%h err=%b",
						$time, path_token, node, step_count, node_range_error);
					mismatches++;
				end else begin
					head_token = pending_tokens.pop_front();
					check_field("path_token", 32'(head_token.path), 32'(path_token));
					check_field("node", 32'(head_token.node), 32'(node));
					check_field("step_count", head_token.steps, step_count);
					check_field("node_range_error", 32'(head_token.err),
						32'(node_range_error));
				end
			end
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_window(bytes_sent) && $urandom_range(0, 99) < 6) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles in which no request moves on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog expired after %0d idle cycles", $time, quiet_cycles);
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule

### filelist.f
+incdir+sv
sv/ntd_pkg.sv
sv/ntd_varint.sv
sv/ntd_cache.sv
sv/neighbor_token_decoder.sv
sv/ntd_checker.sv
sim/testbench.sv
